// ===== sv/lrcp_pkg.sv =====
// Shared types and constants of the framed register poller.
// Used by every module of the block; the channel interfaces do not use it.
`default_nettype none
package lrcp_pkg;

  // Input item kinds.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Result item kinds.
  localparam logic [1:0] RES_TX     = 2'd0;
  localparam logic [1:0] RES_STATUS = 2'd1;
  localparam logic [1:0] RES_READ   = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] CFG_TIMEOUT = 8'd0;
  localparam logic [7:0] CFG_GAP     = 8'd1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd250;
  localparam logic [15:0] GAP_RESET     = 16'd1000;

  // Frame bytes.
  localparam logic [7:0] FRAME_START = 8'h3A;
  localparam logic [7:0] FUNC_READ   = 8'h04;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [3:0] REQ_LEN     = 4'd10;

  // Depth of the queue between front and back.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  // One queued input item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [2:0] read_pack;
    logic [7:0] read_addr;
  } q_item_t;

  // Queue read side as seen by the back end.
  typedef struct packed {
    logic    empty;
    q_item_t item;
  } q_head_t;

  // Configuration register values.
  typedef struct packed {
    logic [15:0] reply_timeout_ticks;
    logic [15:0] cycle_gap_ticks;
  } cfg_t;

endpackage
`default_nettype wire

// ===== sv/lrcp_ifs.sv =====
// Channel interfaces of the framed register poller: input, result and config.
// Depends on nothing but plain logic types.
`default_nettype none
interface lrcp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic [2:0] read_pack;
  logic [7:0] read_addr;
  modport source (output valid, req_type, rx_byte, read_pack, read_addr, input ready);
  modport sink (input valid, req_type, rx_byte, read_pack, read_addr, output ready);
endinterface

interface lrcp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [2:0]  pack_index;
  logic        pack_ok;
  logic        cycle_done;
  logic        any_ok;
  logic [31:0] error_count;
  logic [15:0] read_data;
  modport source (output valid, result_kind, tx_byte, last, pack_index, pack_ok,
                  cycle_done, any_ok, error_count, read_data, input ready);
  modport sink (input valid, result_kind, tx_byte, last, pack_index, pack_ok,
                cycle_done, any_ok, error_count, read_data, output ready);
endinterface

interface lrcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/lrcp_fifo.sv =====
// Short item queue between the front end and the back end.
// Depends on lrcp_pkg for the item type and depth.
`default_nettype none
module lrcp_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lrcp_pkg::q_item_t push_item,
  output logic                   full,
  input  wire logic              pop,
  output lrcp_pkg::q_head_t      head
);

  lrcp_pkg::q_item_t        mem_r [lrcp_pkg::Q_DEPTH];
  logic [lrcp_pkg::Q_AW-1:0] wptr_r, rptr_r;
  logic [lrcp_pkg::Q_AW:0]   cnt_r;

  assign full       = (cnt_r == (lrcp_pkg::Q_AW+1)'(lrcp_pkg::Q_DEPTH));
  assign head.empty = (cnt_r == '0);
  assign head.item  = mem_r[rptr_r];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lrcp_front.sv =====
// Front end: accepts input items, drops unknown kinds and queues the rest.
// Depends on lrcp_pkg and lrcp_in_if.
`default_nettype none
module lrcp_front (
  lrcp_in_if.sink             in_ch,
  input  wire logic           q_full,
  output logic                push,
  output lrcp_pkg::q_item_t   push_item
);

  // An item is taken whenever the queue has room.
  assign in_ch.ready = !q_full;

  // Unknown kinds produce nothing, so they never enter the queue.
  assign push = in_ch.valid && !q_full && (in_ch.req_type != lrcp_pkg::REQ_NONE);

  assign push_item.kind      = in_ch.req_type;
  assign push_item.rx_byte   = in_ch.rx_byte;
  assign push_item.read_pack = in_ch.read_pack;
  assign push_item.read_addr = in_ch.read_addr;

endmodule
`default_nettype wire

// ===== sv/lrcp_back.sv =====
// Back end: poll sequencer, reply buffer, frame check and register store.
// Depends on lrcp_pkg and lrcp_out_if.
`default_nettype none
module lrcp_back #(
  parameter int unsigned SLAVES    = 2,
  parameter int unsigned REG_COUNT = 36,
  parameter int unsigned RX_DEPTH  = 160
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lrcp_pkg::cfg_t    cfg,
  input  wire lrcp_pkg::q_head_t head,
  output logic                   pop,
  lrcp_out_if.source             out_ch
);

  localparam int unsigned LW   = $clog2(RX_DEPTH + 1);
  localparam int unsigned BAW  = $clog2(RX_DEPTH);
  localparam int unsigned RIW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned SDEP = SLAVES * REG_COUNT;
  localparam int unsigned SAW  = (SDEP > 1) ? $clog2(SDEP) : 1;
  localparam logic [15:0] RC16 = 16'(REG_COUNT);
  localparam logic [7:0]  REQ_LRC = 8'(8'd0 - (lrcp_pkg::FUNC_READ + RC16[15:8] + RC16[7:0]));

  typedef enum logic [3:0] {
    S_IDLE, S_RD_OUT, S_TX, S_STAT, S_CHK_RD, S_CHK_USE, S_ST_A, S_ST_B, S_ST_C
  } state_t;

  state_t        state_r;
  logic          waiting_r;
  logic [2:0]    cur_r;
  logic [15:0]   wait_r, gap_r;
  logic [LW-1:0] len_r, n_r;
  logic [7:0]    prev_r;
  logic [3:0]    txc_r;
  logic          fin_ok_r;
  logic [BAW-1:0] idx_r;
  logic [7:0]    sum_r, f0_r, f1_r, f3_r, hi_r;
  logic [RIW-1:0] ri_r;
  logic [SLAVES-1:0] slave_ok_r, row_valid_r;
  logic [31:0]   err_r;
  logic          rd_hit_r;

  logic          out_valid_r;
  logic [1:0]    o_kind_r;
  logic [7:0]    o_tx_r;
  logic          o_last_r, o_ok_r, o_done_r, o_any_r;
  logic [2:0]    o_pack_r;
  logic [31:0]   o_err_r;
  logic [15:0]   o_data_r;

  // Memories.
  logic [7:0]    buf_mem [RX_DEPTH];
  logic [15:0]   st_mem [SDEP];
  logic [7:0]    buf_rdata_r;
  logic [15:0]   st_rdata_r;

  logic           buf_we;
  logic [BAW-1:0] buf_waddr, buf_raddr;
  logic           st_we;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic           rd_range;
  logic [15:0]    st_rsum, st_wsum, bidx;
  logic           out_free;
  lrcp_pkg::q_item_t it;

  assign it       = head.item;
  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = (state_r == S_IDLE) && !head.empty;

  // Memory address and enable decode.
  always_comb begin
    rd_range  = (4'(it.read_pack) < 4'(SLAVES)) && (9'(it.read_addr) < 9'(REG_COUNT));
    st_rsum   = 16'(it.read_pack) * RC16 + 16'(it.read_addr);
    st_raddr  = rd_range ? st_rsum[SAW-1:0] : '0;
    st_wsum   = 16'(cur_r) * RC16 + 16'(ri_r);
    st_waddr  = st_wsum[SAW-1:0];
    st_we     = (state_r == S_ST_C);
    buf_we    = pop && (it.kind == lrcp_pkg::REQ_BYTE) && waiting_r &&
                (len_r < LW'(RX_DEPTH));
    buf_waddr = len_r[BAW-1:0];
    bidx      = 16'd4 + {15'd0, 1'b0} + 16'(ri_r) * 16'd2;
    unique case (state_r)
      S_CHK_RD: buf_raddr = idx_r;
      S_ST_A:   buf_raddr = bidx[BAW-1:0];
      S_ST_B:   buf_raddr = BAW'(bidx + 16'd1);
      default:  buf_raddr = '0;
    endcase
  end

  // Reply buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_waddr] <= it.rx_byte;
    buf_rdata_r <= buf_mem[buf_raddr];
  end

  // Register store: one write port, one registered read port.
  // The read data is held from the pop of a read until the result is loaded.
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= {hi_r, buf_rdata_r};
    if (pop) st_rdata_r <= st_mem[st_raddr];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = o_kind_r;
  assign out_ch.tx_byte     = o_tx_r;
  assign out_ch.last        = o_last_r;
  assign out_ch.pack_index  = o_pack_r;
  assign out_ch.pack_ok     = o_ok_r;
  assign out_ch.cycle_done  = o_done_r;
  assign out_ch.any_ok      = o_any_r;
  assign out_ch.error_count = o_err_r;
  assign out_ch.read_data   = o_data_r;

  // Sequencer with its state and the output register.
  always_ff @(posedge clk) begin
    logic [15:0]   tk;
    logic [LW-1:0] ln;
    logic          more, any, ok;
    logic [7:0]    b;
    logic          ov, hit;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      waiting_r   <= 1'b0;
      cur_r       <= '0;
      wait_r      <= '0;
      gap_r       <= 16'hFFFF;
      len_r       <= '0;
      slave_ok_r  <= '0;
      row_valid_r <= '0;
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ov = out_valid_r && !out_ch.ready;
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            unique case (it.kind)
              lrcp_pkg::REQ_TICK: begin
                if (!waiting_r) begin
                  tk = (gap_r == 16'hFFFF) ? gap_r : gap_r + 16'd1;
                  gap_r <= tk;
                  if (tk >= cfg.cycle_gap_ticks) begin
                    cur_r     <= '0;
                    len_r     <= '0;
                    wait_r    <= '0;
                    waiting_r <= 1'b1;
                    txc_r     <= '0;
                    state_r   <= S_TX;
                  end
                end else begin
                  tk = (wait_r == 16'hFFFF) ? wait_r : wait_r + 16'd1;
                  wait_r <= tk;
                  if (tk >= cfg.reply_timeout_ticks) begin
                    fin_ok_r <= 1'b0;
                    state_r  <= S_STAT;
                  end
                end
              end
              lrcp_pkg::REQ_BYTE: begin
                if (buf_we) begin
                  ln = len_r + 1'b1;
                  len_r  <= ln;
                  prev_r <= it.rx_byte;
                  // CR LF anywhere ends the reply.
                  if (len_r != '0 && prev_r == lrcp_pkg::BYTE_CR &&
                      it.rx_byte == lrcp_pkg::BYTE_LF) begin
                    if (ln < LW'(8)) begin
                      fin_ok_r <= 1'b0;
                      state_r  <= S_STAT;
                    end else begin
                      n_r     <= ln;
                      idx_r   <= '0;
                      sum_r   <= '0;
                      state_r <= S_CHK_RD;
                    end
                  end
                end
              end
              lrcp_pkg::REQ_READ: begin
                hit = 1'b0;
                for (int s = 0; s < SLAVES; s++) begin
                  if (4'(it.read_pack) == 4'(s) && row_valid_r[s] && rd_range) hit = 1'b1;
                end
                rd_hit_r <= hit;
                state_r  <= S_RD_OUT;
              end
              default: ;
            endcase
          end
        end
        S_RD_OUT: begin
          if (out_free) begin
            ov = 1'b1;
            o_kind_r <= lrcp_pkg::RES_READ;
            o_tx_r <= '0; o_last_r <= 1'b1; o_pack_r <= '0; o_ok_r <= 1'b0;
            o_done_r <= 1'b0; o_any_r <= 1'b0; o_err_r <= '0;
            o_data_r <= rd_hit_r ? st_rdata_r : 16'd0;
            state_r  <= S_IDLE;
          end
        end
        S_TX: begin
          if (out_free) begin
            ov = 1'b1;
            o_kind_r <= lrcp_pkg::RES_TX;
            o_pack_r <= '0; o_ok_r <= 1'b0; o_done_r <= 1'b0; o_any_r <= 1'b0;
            o_err_r <= '0; o_data_r <= '0;
            o_last_r <= (txc_r == lrcp_pkg::REQ_LEN - 4'd1);
            unique case (txc_r)
              4'd0:    o_tx_r <= lrcp_pkg::FRAME_START;
              4'd1:    o_tx_r <= 8'(cur_r) + 8'd1;
              4'd2:    o_tx_r <= lrcp_pkg::FUNC_READ;
              4'd5:    o_tx_r <= RC16[15:8];
              4'd6:    o_tx_r <= RC16[7:0];
              4'd7:    o_tx_r <= REQ_LRC - 8'(cur_r) - 8'd1;
              4'd8:    o_tx_r <= lrcp_pkg::BYTE_CR;
              4'd9:    o_tx_r <= lrcp_pkg::BYTE_LF;
              default: o_tx_r <= 8'd0;
            endcase
            txc_r <= txc_r + 4'd1;
            if (txc_r == lrcp_pkg::REQ_LEN - 4'd1) state_r <= S_IDLE;
          end
        end
        S_STAT: begin
          if (out_free) begin
            ok   = fin_ok_r;
            more = (4'(cur_r) + 4'd1) < 4'(SLAVES);
            any  = 1'b0;
            for (int s = 0; s < SLAVES; s++) begin
              if (4'(cur_r) == 4'(s)) begin
                slave_ok_r[s] <= ok;
                any = any | ok;
              end else begin
                any = any | slave_ok_r[s];
              end
            end
            err_r <= err_r + {31'd0, !ok};
            ov = 1'b1;
            o_kind_r <= lrcp_pkg::RES_STATUS;
            o_tx_r <= '0; o_data_r <= '0;
            o_pack_r <= cur_r;
            o_ok_r   <= ok;
            o_done_r <= !more;
            o_any_r  <= !more && any;
            o_last_r <= !more;
            o_err_r  <= err_r + {31'd0, !ok};
            len_r    <= '0;
            if (more) begin
              cur_r     <= cur_r + 3'd1;
              wait_r    <= '0;
              waiting_r <= 1'b1;
              txc_r     <= '0;
              state_r   <= S_TX;
            end else begin
              cur_r     <= '0;
              waiting_r <= 1'b0;
              gap_r     <= '0;
              state_r   <= S_IDLE;
            end
          end
        end
        S_CHK_RD: state_r <= S_CHK_USE;
        S_CHK_USE: begin
          // Capture header bytes and sum the bytes after the start through the LRC.
          b = buf_rdata_r;
          if (idx_r == BAW'(0)) f0_r <= b;
          if (idx_r == BAW'(1)) f1_r <= b;
          if (idx_r == BAW'(3)) f3_r <= b;
          if (idx_r != '0) sum_r <= sum_r + b;
          if (LW'(idx_r) == n_r - LW'(3)) begin
            if (f0_r == lrcp_pkg::FRAME_START && (sum_r + b) == 8'd0 &&
                f1_r == 8'(cur_r) + 8'd1 && 9'(f3_r) >= 9'(2 * REG_COUNT) &&
                9'(f3_r) + 9'd3 <= 9'(n_r) - 9'd4) begin
              ri_r    <= '0;
              state_r <= S_ST_A;
            end else begin
              fin_ok_r <= 1'b0;
              state_r  <= S_STAT;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_CHK_RD;
          end
        end
        S_ST_A: state_r <= S_ST_B;
        S_ST_B: begin
          hi_r    <= buf_rdata_r;
          state_r <= S_ST_C;
        end
        S_ST_C: begin
          if (ri_r == RIW'(REG_COUNT - 1)) begin
            for (int s = 0; s < SLAVES; s++) begin
              if (4'(cur_r) == 4'(s)) row_valid_r[s] <= 1'b1;
            end
            fin_ok_r <= 1'b1;
            state_r  <= S_STAT;
          end else begin
            ri_r    <= ri_r + 1'b1;
            state_r <= S_ST_A;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      out_valid_r <= ov;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lrc_framed_register_poller_core.sv =====
// Top level of the framed register poller: config registers, front, queue, back.
// Depends on lrcp_pkg, lrcp_ifs, lrcp_front, lrcp_fifo and lrcp_back.
//
//  Channel   Direction  Contents
//  in_ch     sink       req_type, rx_byte, read_pack, read_addr
//  out_ch    source     result_kind, tx_byte, last, pack_index, pack_ok,
//                       cycle_done, any_ok, error_count, read_data
//  cfg_ch    sink       index, data (0 reply timeout, 1 cycle gap)
//
// Each item passes through the queue; a tick or byte without results is done at its pop,
// a read does the store read, then the output, and each result waits for a free output.
// A reply that ends in CR LF is checked over the reply buffer's single read port, then, if
// the frame is good, stored in S_ST_A, S_ST_B and S_ST_C, two buffer reads per register.
// Synchronous active-low reset; a read returns zero until its slave's row is filled.
// A four-item queue lets input items be taken while the back end waits on out_ch.ready.
`default_nettype none
module lrc_framed_register_poller_core #(
  parameter int unsigned SLAVES    = 2,
  parameter int unsigned REG_COUNT = 36,
  parameter int unsigned RX_DEPTH  = 160
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lrcp_in_if.sink     in_ch,
  lrcp_out_if.source  out_ch,
  lrcp_cfg_if.sink    cfg_ch
);

  lrcp_pkg::cfg_t    cfg_r;
  lrcp_pkg::q_item_t push_item;
  lrcp_pkg::q_head_t head;
  logic              push, pop, q_full;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reply_timeout_ticks <= lrcp_pkg::TIMEOUT_RESET;
      cfg_r.cycle_gap_ticks     <= lrcp_pkg::GAP_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == lrcp_pkg::CFG_TIMEOUT) cfg_r.reply_timeout_ticks <= cfg_ch.data;
      else if (cfg_ch.index == lrcp_pkg::CFG_GAP) cfg_r.cycle_gap_ticks <= cfg_ch.data;
    end
  end

  lrcp_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  lrcp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  lrcp_back #(
    .SLAVES    (SLAVES),
    .REG_COUNT (REG_COUNT),
    .RX_DEPTH  (RX_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
